[rtl/id3v2_tag_size_checker_top_defines.svh]
// Assertion macros for the ID3v2 tag size checker.
`ifndef ID3V2_TAG_SIZE_CHECKER_TOP_DEFINES_SVH
`define ID3V2_TAG_SIZE_CHECKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ITSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itsc: implication check failed");
// Next-cycle implication.
`define ITSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itsc: next-cycle check failed");
`else
`define ITSC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ITSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/itsc_pkg.sv]
// Types and constants shared by the ID3v2 tag size checker files.
package itsc_pkg;

   localparam int DATA_W       = 8;
   localparam int STATUS_W     = 3;
   localparam int TAG_SIZE_W   = 29;
   localparam int CORR_W       = 28;
   localparam int SAFE_W       = 31;

   localparam int HEADER_LEN   = 10;
   localparam int FOOTER_LEN   = 10;

   localparam logic [7:0] SYNC_FIRST    = 8'hFF;
   localparam logic [7:0] SYNC_SECOND_A = 8'hFB;
   localparam logic [7:0] SYNC_SECOND_B = 8'hFA;
   localparam logic [7:0] ID_CHAR_I     = 8'h49;
   localparam logic [7:0] ID_CHAR_D     = 8'h44;
   localparam logic [7:0] ID_CHAR_3     = 8'h33;
   localparam logic [7:0] VERSION_LIMIT = 8'hFF;
   localparam logic [7:0] SAFE_LIMIT    = 8'h80;
   localparam logic [7:0] SAFE_MASK     = 8'h7F;
   localparam logic [7:0] FOOTER_FLAG   = 8'h10;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_SYNC_START       = 3'd0,
      STATUS_NO_TAG           = 3'd1,
      STATUS_TAG_OK           = 3'd2,
      STATUS_BROKEN_CORRECTED = 3'd3,
      STATUS_BROKEN_NO_SYNC   = 3'd4
   } status_type;

endpackage

[rtl/itsc_channels.sv]
// Valid/ready channel interfaces for the byte input and the status result.
interface itsc_req_if import itsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface itsc_rsp_if import itsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [TAG_SIZE_W-1:0] tag_size;
   logic [CORR_W-1:0]     corrected_size;
   logic [SAFE_W-1:0]     corrected_synchsafe;

   modport source (output valid, output status, output tag_size, output corrected_size,
                   output corrected_synchsafe, input ready);
   modport sink   (input valid, input status, input tag_size, input corrected_size,
                   input corrected_synchsafe, output ready);
endinterface

[rtl/id3v2_tag_size_checker_top.sv]
// Top level of the ID3v2 tag size checker: byte stream in, one status per file out.
//
// Usage: stream a file on req_chan one byte per transaction from offset zero, with
// last_byte set on the final byte. Each file yields exactly one transaction on
// rsp_chan carrying status, the decoded tag size and, for a broken tag, the
// corrected size as a plain value and in synchsafe form.
// Datapath: a one-entry input register, then compare/add logic that
// updates the per-file state, then an output register for the result.
// Throughput: one byte per cycle, sustained; req_chan.ready stays high while the
// input register can drain.
// Result path: a last byte is accepted into the input register, then processed
// into the output register that drives rsp_chan; a waiting result can hold it in
// the input register in between.
// Stall: while a result waits in the output register, non-last bytes of the next
// file keep flowing; a last byte waits in the input register, with ready low, until
// the waiting result is taken.
// Reset: synchronous, active high; clears the position counter, the match flags
// and the valid bits of both channel registers. The per-file state is cleared the
// same way after every last byte, so the next file may follow at once. The header byte store needs no clearing.
// The position counter saturates at its all-ones value.
`include "id3v2_tag_size_checker_top_defines.svh"

module id3v2_tag_size_checker_top import itsc_pkg::*; #(
   parameter int POSITION_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   itsc_req_if.sink   req_chan,
   itsc_rsp_if.source rsp_chan
);

   // Compare width: wide enough for the position and for tag end offsets.
   localparam int CmpW = (POSITION_BITS > 30) ? POSITION_BITS : 30;
   localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // Per-file state
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [7:0]               hs_ff [HEADER_LEN];
   logic [7:0]               hs_in [HEADER_LEN];
   logic [TAG_SIZE_W-1:0]    tag_end_ff, tag_end_in;
   logic                     thv_ff, thv_in;
   logic [7:0]               prev_ff, prev_in;
   logic                     sate_ff, sate_in;
   logic                     fsf_ff, fsf_in;
   logic [POSITION_BITS-1:0] fsp_ff, fsp_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [TAG_SIZE_W-1:0] tsize_ff, tsize_in;
   logic [CORR_W-1:0]     corr_ff, corr_in;
   logic [SAFE_W-1:0]     safe_ff, safe_in;

   logic out_free;
   logic process;
   logic load_result;

   // Values after this byte, before the end-of-file clear
   logic [TAG_SIZE_W-1:0]    n_tag_end;
   logic                     n_thv;
   logic                     n_sate;
   logic                     n_fsf;
   logic [POSITION_BITS-1:0] n_fsp;
   logic                     hdr_ok;
   logic [CORR_W-1:0]        synch_val;
   logic [TAG_SIZE_W-1:0]    tag_end_calc;
   logic                     sync_hit;
   logic                     footer;
   logic [CmpW-1:0]          p_ext;
   logic [CmpW-1:0]          fsp_ext;

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign process     = in_valid_ff && (!in_last_ff || out_free);
   assign load_result = process && in_last_ff;

   assign req_chan.ready = !in_valid_ff || process;
   assign in_valid_in    = (req_chan.valid && req_chan.ready) ? 1'b1 :
                           (process ? 1'b0 : in_valid_ff);

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.status              = status_ff;
   assign rsp_chan.tag_size            = tsize_ff;
   assign rsp_chan.corrected_size      = corr_ff;
   assign rsp_chan.corrected_synchsafe = safe_ff;

   assign rsp_valid_in = load_result || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      hs_in = hs_ff;
      if (pos_ff < POSITION_BITS'(HEADER_LEN)) begin
         hs_in[pos_ff[3:0]] = in_byte_ff;
      end

      // Header pattern and synchsafe size, seen with the current byte in place
      hdr_ok = hs_in[0] == ID_CHAR_I && hs_in[1] == ID_CHAR_D && hs_in[2] == ID_CHAR_3 &&
               hs_in[3] < VERSION_LIMIT && hs_in[4] < VERSION_LIMIT &&
               hs_in[6] < SAFE_LIMIT && hs_in[7] < SAFE_LIMIT &&
               hs_in[8] < SAFE_LIMIT && hs_in[9] < SAFE_LIMIT;
      footer    = (hs_in[5] & FOOTER_FLAG) != 8'h00;
      synch_val = {hs_in[6][6:0], hs_in[7][6:0], hs_in[8][6:0], hs_in[9][6:0]};
      tag_end_calc = TAG_SIZE_W'(synch_val) + TAG_SIZE_W'(HEADER_LEN) +
                     (footer ? TAG_SIZE_W'(FOOTER_LEN) : '0);

      n_thv     = thv_ff;
      n_tag_end = tag_end_ff;
      if (pos_ff == POSITION_BITS'(HEADER_LEN - 1)) begin
         n_thv     = hdr_ok;
         n_tag_end = tag_end_calc;
      end

      p_ext    = CmpW'(pos_ff);
      sync_hit = (pos_ff != '0) && prev_ff == SYNC_FIRST &&
                 (in_byte_ff == SYNC_SECOND_A || in_byte_ff == SYNC_SECOND_B);

      n_fsf = fsf_ff;
      n_fsp = fsp_ff;
      if (sync_hit && !fsf_ff) begin
         n_fsf = 1'b1;
         n_fsp = pos_ff - POSITION_BITS'(1);
      end

      n_sate = sate_ff;
      if (sync_hit && pos_ff >= POSITION_BITS'(HEADER_LEN) && thv_ff &&
          p_ext == CmpW'(tag_end_ff) + CmpW'(1)) begin
         n_sate = 1'b1;
      end

      // Result for a last byte
      fsp_ext  = CmpW'(n_fsp);
      tsize_in = '0;
      corr_in  = '0;
      if (pos_ff != '0 && hs_in[0] == SYNC_FIRST &&
          (hs_in[1] == SYNC_SECOND_A || hs_in[1] == SYNC_SECOND_B)) begin
         status_in = STATUS_SYNC_START;
      end else if (pos_ff < POSITION_BITS'(HEADER_LEN - 1) || !n_thv) begin
         status_in = STATUS_NO_TAG;
      end else begin
         tsize_in = n_tag_end;
         if (n_sate && CmpW'(n_tag_end) + CmpW'(3) <= p_ext) begin
            status_in = STATUS_TAG_OK;
         end else if (n_fsf) begin
            status_in = STATUS_BROKEN_CORRECTED;
            corr_in   = fsp_ext[CORR_W-1:0] - CORR_W'(HEADER_LEN) -
                        (footer ? CORR_W'(FOOTER_LEN) : '0);
         end else begin
            status_in = STATUS_BROKEN_NO_SYNC;
         end
      end
      safe_in = {corr_in[27:21], 1'b0, corr_in[20:14], 1'b0,
                 corr_in[13:7], 1'b0, corr_in[6:0]};

      // Hold unless a byte moves through; drop all file state after the last byte
      pos_in     = pos_ff;
      tag_end_in = tag_end_ff;
      thv_in     = thv_ff;
      prev_in    = prev_ff;
      sate_in    = sate_ff;
      fsf_in     = fsf_ff;
      fsp_in     = fsp_ff;
      if (process) begin
         if (in_last_ff) begin
            pos_in     = '0;
            tag_end_in = '0;
            thv_in     = 1'b0;
            prev_in    = '0;
            sate_in    = 1'b0;
            fsf_in     = 1'b0;
            fsp_in     = '0;
         end else begin
            pos_in     = (pos_ff == PosMax) ? pos_ff : pos_ff + POSITION_BITS'(1);
            tag_end_in = n_tag_end;
            thv_in     = n_thv;
            prev_in    = in_byte_ff;
            sate_in    = n_sate;
            fsf_in     = n_fsf;
            fsp_in     = n_fsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         tag_end_ff   <= '0;
         thv_ff       <= 1'b0;
         prev_ff      <= '0;
         sate_ff      <= 1'b0;
         fsf_ff       <= 1'b0;
         fsp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         tag_end_ff   <= tag_end_in;
         thv_ff       <= thv_in;
         prev_ff      <= prev_in;
         sate_ff      <= sate_in;
         fsf_ff       <= fsf_in;
         fsp_ff       <= fsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
      if (process) begin
         hs_ff <= hs_in;
      end
      if (load_result) begin
         status_ff <= status_in;
         tsize_ff  <= tsize_in;
         corr_ff   <= corr_in;
         safe_ff   <= safe_in;
      end
   end

   // A last byte leaves the per-file state cleared
   `ITSC_ASSERT_NEXT(a_clear_after_last, clock, reset, load_result, pos_ff == '0 && !thv_ff && !fsf_ff)
   // A result appears only after a last byte has been processed
   `ITSC_ASSERT_IMPLY(a_result_source, clock, reset, $rose(rsp_valid_ff), $past(load_result))
   // A held input transaction is not overwritten
   `ITSC_ASSERT_NEXT(a_input_hold, clock, reset, in_valid_ff && !process, in_valid_ff && $stable(in_byte_ff))
   // Corrected fields are zero unless the tag was broken and corrected
   `ITSC_ASSERT_IMPLY(a_corr_zero, clock, reset, rsp_valid_ff && status_ff != STATUS_BROKEN_CORRECTED, corr_ff == '0 && safe_ff == '0)

endmodule

[test/tb_top.sv]
// Self-checking testbench for the ID3v2 tag size checker: byte streams in, one status per file.
module tb_top;
   import itsc_pkg::*;

   // A position counter narrower than the block's default.
   localparam int          POS_BITS   = 16;
   localparam logic [63:0] POS_MAX    = (64'd1 << POS_BITS) - 64'd1;
   localparam int          CYCLE_CAP  = 1_000_000;
   localparam int          DRAIN_WAIT = 20;
   localparam int          HOLD_LEN   = 400;
   localparam int          RAND_BYTES = 220;
   localparam int          RAND_FILES = 12;
   localparam int          NUM_ROWS   = 19;

   // Idling phases: both sides busy, sender gaps, receiver stalls, light gaps on both.
   localparam int PH_BUSY = 0;
   localparam int PH_SEND = 1;
   localparam int PH_RECV = 2;
   localparam int PH_BOTH = 3;

   typedef struct packed {
      status_type       status;
      logic [28:0]      tag_size;
      logic [27:0]      corr_size;
      logic [30:0]      corr_safe;
   } file_result_type;

   localparam file_result_type RES_NO_TAG     = '{STATUS_NO_TAG, 29'd0, 28'd0, 31'd0};
   localparam file_result_type RES_SYNC_START = '{STATUS_SYNC_START, 29'd0, 28'd0, 31'd0};

   // One directed file: ten leading bytes, length, an optional frame sync laid over it.
   typedef struct {
      logic [79:0]     head;
      int              len;
      int              sync_off;
      logic [7:0]      sync_b2;
      bit              typed;
      file_result_type want;
   } file_row_type;

   typedef struct {
      logic [7:0]      data;
      logic            last;
      int              phase;
      bit              typed;
      file_result_type want;
      bit              hold_off;
   } byte_item_type;

   logic clock;
   logic reset;

   itsc_req_if req_chan ();
   itsc_rsp_if rsp_chan ();

   id3v2_tag_size_checker_top #(.POSITION_BITS(POS_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   byte_item_type   byte_stream [$];
   file_result_type awaited_status [$];
   file_row_type    dir_rows [NUM_ROWS];
   byte_item_type   next_byte;
   byte_item_type   sent_item;
   file_result_type oldest;
   bit              failed;
   int              cur_phase;
   bit              pressure_go;
   bit              hold_done;
   int              hold_left;
   int              cycles;

   // Shadow of the per-file state of the block.
   logic [63:0]  trk_pos;
   logic [7:0]   trk_hdr [10];
   logic [28:0]  trk_tag_end;
   bit           trk_hdr_ok;
   logic [7:0]   trk_prev;
   bit           trk_end_sync;
   bit           trk_sync_seen;
   logic [63:0]  trk_sync_pos;

   function automatic bit roll(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic bit is_sync2(input logic [7:0] b);
      return b == SYNC_SECOND_A || b == SYNC_SECOND_B;
   endfunction

   function automatic logic [7:0] noise_byte();
      int r;
      r = $urandom_range(0, 31);
      if (r == 0) return SYNC_FIRST;
      if (r == 1) return SYNC_SECOND_A;
      if (r == 2) return SYNC_SECOND_B;
      return 8'($urandom_range(0, 255));
   endfunction

   // "ID3", version 4.0, flags, synchsafe size.
   function automatic logic [79:0] id3_head(input logic [27:0] sz, input logic [7:0] flags);
      return {ID_CHAR_I, ID_CHAR_D, ID_CHAR_3, 8'h04, 8'h00, flags,
              1'b0, sz[27:21], 1'b0, sz[20:14], 1'b0, sz[13:7], 1'b0, sz[6:0]};
   endfunction

   function automatic logic [28:0] footer_len();
      return ((trk_hdr[5] & FOOTER_FLAG) != 8'h00) ? 29'(FOOTER_LEN) : 29'd0;
   endfunction

   function automatic void clear_tracker();
      trk_pos       = '0;
      foreach (trk_hdr[i]) trk_hdr[i] = '0;
      trk_tag_end   = '0;
      trk_hdr_ok    = 1'b0;
      trk_prev      = '0;
      trk_end_sync  = 1'b0;
      trk_sync_seen = 1'b0;
      trk_sync_pos  = '0;
   endfunction

   // Advance the shadow state by one accepted byte; on the last byte queue the file status.
   function automatic void track_byte(input byte_item_type it);
      logic [63:0]     p;
      logic [27:0]     sz;
      logic [27:0]     corr;
      file_result_type r;
      p = trk_pos;
      if (p < 64'd10) trk_hdr[p[3:0]] = it.data;
      if (p == 64'd9) begin
         trk_hdr_ok = trk_hdr[0] == ID_CHAR_I && trk_hdr[1] == ID_CHAR_D &&
                      trk_hdr[2] == ID_CHAR_3 && trk_hdr[3] < VERSION_LIMIT &&
                      trk_hdr[4] < VERSION_LIMIT && trk_hdr[6] < SAFE_LIMIT &&
                      trk_hdr[7] < SAFE_LIMIT && trk_hdr[8] < SAFE_LIMIT &&
                      trk_hdr[9] < SAFE_LIMIT;
         sz = {trk_hdr[6][6:0], trk_hdr[7][6:0], trk_hdr[8][6:0], trk_hdr[9][6:0]};
         trk_tag_end = 29'(sz) + 29'(HEADER_LEN) + footer_len();
      end
      if (p >= 64'd1 && trk_prev == SYNC_FIRST && is_sync2(it.data)) begin
         if (!trk_sync_seen) begin
            trk_sync_seen = 1'b1;
            trk_sync_pos  = p - 64'd1;
         end
         if (p >= 64'd10 && trk_hdr_ok && p == 64'(trk_tag_end) + 64'd1)
            trk_end_sync = 1'b1;
      end
      trk_prev = it.data;
      if (trk_pos < POS_MAX) trk_pos = trk_pos + 64'd1;
      if (!it.last) return;

      r = RES_NO_TAG;
      if (p >= 64'd1 && trk_hdr[0] == SYNC_FIRST && is_sync2(trk_hdr[1])) begin
         r.status = STATUS_SYNC_START;
      end else if (p < 64'd9 || !trk_hdr_ok) begin
         r.status = STATUS_NO_TAG;
      end else begin
         r.tag_size = trk_tag_end;
         if (trk_end_sync && 64'(trk_tag_end) + 64'd3 <= p) begin
            r.status = STATUS_TAG_OK;
         end else if (trk_sync_seen) begin
            // Offsets before the header and footer wrap modulo 2^28.
            corr = 28'(trk_sync_pos - 64'(HEADER_LEN) - 64'(footer_len()));
            r.status    = STATUS_BROKEN_CORRECTED;
            r.corr_size = corr;
            r.corr_safe = {corr[27:21], 1'b0, corr[20:14], 1'b0, corr[13:7], 1'b0, corr[6:0]};
         end else begin
            r.status = STATUS_BROKEN_NO_SYNC;
         end
      end
      awaited_status.push_back(it.typed ? it.want : r);
      clear_tracker();
   endfunction

   // Build the whole byte stream up front: directed files first, then random ones.
   initial begin : build
      byte_item_type it;
      logic [7:0]    fb [$];
      logic [79:0]   hd;
      logic [7:0]    b;
      int            f, o, total, kind, len, tag_end, at, sz;

      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;
      failed      = 1'b0;
      cur_phase   = PH_BUSY;
      pressure_go = 1'b0;
      hold_done   = 1'b0;
      hold_left   = 0;
      cycles      = 0;
      clear_tracker();

      dir_rows = '{
         // one-byte files, with and without a leading 0xFF
         '{{8'h00, 72'h0}, 1, -1, SYNC_SECOND_A, 1'b1, RES_NO_TAG},
         '{{SYNC_FIRST, 72'h0}, 1, -1, SYNC_SECOND_A, 1'b1, RES_NO_TAG},
         // frame sync at the start, shortest and longer, and a near miss with 0xFC
         '{{SYNC_FIRST, SYNC_SECOND_A, 64'h0}, 2, -1, SYNC_SECOND_A, 1'b1, RES_SYNC_START},
         '{{SYNC_FIRST, SYNC_SECOND_B, ID_CHAR_I, ID_CHAR_D, ID_CHAR_3, 40'h0}, 12, -1,
           SYNC_SECOND_A, 1'b1, RES_SYNC_START},
         '{{SYNC_FIRST, 8'hFC, 64'h0}, 5, -1, SYNC_SECOND_A, 1'b1, RES_NO_TAG},
         // valid header cut short of ten bytes
         '{id3_head(28'd0, 8'h00), 9, -1, SYNC_SECOND_A, 1'b1, RES_NO_TAG},
         // sync right at the tag end, just long enough, then one byte too short, then with a footer
         '{id3_head(28'd0, 8'h00), 14, 10, SYNC_SECOND_A, 1'b1,
           '{STATUS_TAG_OK, 29'd10, 28'd0, 31'd0}},
         '{id3_head(28'd0, 8'h00), 13, 10, SYNC_SECOND_B, 1'b1,
           '{STATUS_BROKEN_CORRECTED, 29'd10, 28'd0, 31'd0}},
         '{id3_head(28'd5, FOOTER_FLAG), 29, 25, SYNC_SECOND_A, 1'b1,
           '{STATUS_TAG_OK, 29'd25, 28'd0, 31'd0}},
         // largest synchsafe size, no sync anywhere
         '{id3_head(28'hFFFFFFF, 8'h00), 20, -1, SYNC_SECOND_A, 1'b1,
           '{STATUS_BROKEN_NO_SYNC, 29'd268435465, 28'd0, 31'd0}},
         '{id3_head(28'hFFFFFFF, FOOTER_FLAG), 10, -1, SYNC_SECOND_A, 1'b1,
           '{STATUS_BROKEN_NO_SYNC, 29'd268435475, 28'd0, 31'd0}},
         // early sync inside the footer allowance wraps the corrected size
         '{id3_head(28'd0, FOOTER_FLAG), 24, 10, SYNC_SECOND_A, 1'b1,
           '{STATUS_BROKEN_CORRECTED, 29'd20, 28'd268435446, 31'h7F7F7F76}},
         // ways of breaking the header pattern: a version byte, a size byte, an ID character
         '{id3_head(28'd0, 8'h00) | {24'h0, 8'hFF, 48'h0}, 14, 10, SYNC_SECOND_A, 1'b1,
           RES_NO_TAG},
         '{id3_head(28'd0, 8'h00) | {48'h0, 8'h80, 24'h0}, 14, 10, SYNC_SECOND_A, 1'b1,
           RES_NO_TAG},
         '{id3_head(28'd0, 8'h00) | {72'h0, 8'h80}, 14, 10, SYNC_SECOND_A, 1'b1, RES_NO_TAG},
         '{id3_head(28'd0, 8'h00) ^ {16'h0, 8'h07, 56'h0}, 14, 10, SYNC_SECOND_A, 1'b1,
           RES_NO_TAG},
         // version bytes and flags at their extremes, then two files checked by the shadow state
         '{{ID_CHAR_I, ID_CHAR_D, ID_CHAR_3, 8'hFE, 8'hFE, 8'hFF, 32'h7F7F7F7F}, 30, 20,
           SYNC_SECOND_B, 1'b0, RES_NO_TAG},
         '{id3_head(28'd12, 8'h00), 40, 30, SYNC_SECOND_A, 1'b0, RES_NO_TAG},
         '{id3_head(28'd30, FOOTER_FLAG), 60, 50, SYNC_SECOND_B, 1'b0, RES_NO_TAG}
      };

      foreach (dir_rows[r]) begin
         for (o = 0; o < dir_rows[r].len; o++) begin
            if (dir_rows[r].sync_off >= 0 && o == dir_rows[r].sync_off)
               b = SYNC_FIRST;
            else if (dir_rows[r].sync_off >= 0 && o == dir_rows[r].sync_off + 1)
               b = dir_rows[r].sync_b2;
            else if (o < 10)
               b = dir_rows[r].head[79 - 8 * o -: 8];
            else
               b = 8'h00;
            it.data     = b;
            it.last     = (o == dir_rows[r].len - 1);
            it.phase    = PH_BUSY;
            it.typed    = dir_rows[r].typed;
            it.want     = dir_rows[r].want;
            it.hold_off = 1'b0;
            byte_stream.push_back(it);
         end
      end

      total = 0;
      for (f = 0; total < RAND_BYTES || f < RAND_FILES; f++) begin
         fb.delete();
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            // Header-led file: mostly well formed, some with one field broken.
            sz = roll(10) ? int'($urandom & 32'h0FFFFFFF) : $urandom_range(0, 14);
            hd = id3_head(28'(sz), 8'($urandom_range(0, 255)));
            hd[55:48] = 8'($urandom_range(0, 254));
            hd[47:40] = 8'($urandom_range(0, 254));
            tag_end = sz + HEADER_LEN + (hd[36] ? FOOTER_LEN : 0);
            if (kind >= 55) begin
               at = $urandom_range(0, 8);
               if (at >= 5) at++;
               if (at < 3)
                  hd[79 - 8 * at -: 8] = hd[79 - 8 * at -: 8] ^ 8'($urandom_range(1, 255));
               else if (at < 5)
                  hd[79 - 8 * at -: 8] = VERSION_LIMIT;
               else
                  hd[79 - 8 * at -: 8] = 8'($urandom_range(128, 255));
            end
            if (roll(10))
               len = $urandom_range(1, 10);
            else if (sz > 14)
               len = 10 + $urandom_range(0, 20);
            else
               len = tag_end - 1 + $urandom_range(0, 8);
            for (o = 0; o < len; o++)
               fb.push_back(o < 10 ? hd[79 - 8 * o -: 8] : noise_byte());
            at = $urandom_range(0, 9);
            if (at < 6)
               at = tag_end;
            else if (at < 8)
               at = $urandom_range(10, len);
            else
               at = -1;
            if (at >= 0 && at + 1 < len) begin
               fb[at]     = SYNC_FIRST;
               fb[at + 1] = roll(50) ? SYNC_SECOND_A : SYNC_SECOND_B;
            end
         end else if (kind < 85) begin
            fb.push_back(SYNC_FIRST);
            fb.push_back(roll(50) ? SYNC_SECOND_A : SYNC_SECOND_B);
            len = $urandom_range(0, 10);
            for (o = 0; o < len; o++) fb.push_back(noise_byte());
         end else begin
            len = $urandom_range(1, 14);
            for (o = 0; o < len; o++) fb.push_back(noise_byte());
         end
         for (o = 0; o < fb.size(); o++) begin
            it.data     = fb[o];
            it.last     = (o == fb.size() - 1);
            it.phase    = (f / 3) % 4;
            it.typed    = 1'b0;
            it.want     = RES_NO_TAG;
            it.hold_off = (f == 0 && o == 0);
            byte_stream.push_back(it);
         end
         total += fb.size();
      end
   end

   // Sender: present the next byte unless the phase calls for a gap; hold it until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (byte_stream.size() != 0 &&
             !((byte_stream[0].phase == PH_SEND && roll(77)) ||
               (byte_stream[0].phase == PH_BOTH && roll(7)))) begin
            next_byte = byte_stream.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.data_byte <= next_byte.data;
            req_chan.last_byte <= next_byte.last;
            sent_item          <= next_byte;
            cur_phase          <= next_byte.phase;
            if (next_byte.hold_off) pressure_go <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: one long hold-off so the block backs up, otherwise stall as the phase says.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
         hold_done      <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (pressure_go && !hold_done) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= HOLD_LEN;
         hold_done      <= 1'b1;
      end else begin
         rsp_chan.ready <= !((cur_phase == PH_RECV && roll(77)) ||
                             (cur_phase == PH_BOTH && roll(7)));
      end
   end

   // Track every accepted byte transaction, with the expectation it was sent with.
   always @(posedge clock) begin
      if (reset)
         clear_tracker();
      else if (req_chan.valid && req_chan.ready)
         track_byte(sent_item);
   end

   // Compare each result transaction with the oldest awaited status.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_status.size() == 0) begin
            $error("unexpected result: status %0d tag_size %0d", rsp_chan.status,
                   rsp_chan.tag_size);
            failed = 1'b1;
         end else begin
            oldest = awaited_status.pop_front();
            if (rsp_chan.status !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp_chan.status);
               failed = 1'b1;
            end
            if (rsp_chan.tag_size !== oldest.tag_size) begin
               $error("tag_size: expected %0d, got %0d", oldest.tag_size, rsp_chan.tag_size);
               failed = 1'b1;
            end
            if (rsp_chan.corrected_size !== oldest.corr_size) begin
               $error("corrected_size: expected %0d, got %0d", oldest.corr_size,
                      rsp_chan.corrected_size);
               failed = 1'b1;
            end
            if (rsp_chan.corrected_synchsafe !== oldest.corr_safe) begin
               $error("corrected_synchsafe: expected %h, got %h", oldest.corr_safe,
                      rsp_chan.corrected_synchsafe);
               failed = 1'b1;
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("id3v2_tag_size_checker_top verification failed");
         $finish;
      end
   end

   // Release reset, wait for the stream to drain and every status to arrive, then report.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (byte_stream.size() != 0 || req_chan.valid || awaited_status.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (!failed && awaited_status.size() == 0)
         $display("id3v2_tag_size_checker_top verification clean");
      else
         $display("id3v2_tag_size_checker_top verification failed");
      $finish;
   end

endmodule
